// ----- rtl/wis_pkg.sv -----
package wis_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned DEPTH       = 64;
    localparam int unsigned PTR_W       = $clog2(DEPTH);
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned SUM_W       = TIME_W + PTR_W;
    localparam int unsigned ACC_W       = 2 * TIME_W + PTR_W;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        CMD_PERIOD,
        CMD_DURATION,
        CMD_CLEAR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [TIME_W-1:0]  sample;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage

// ----- rtl/wis_front.sv -----
module wis_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [1:0]                  i_op,
    input  logic [wis_pkg::TIME_W-1:0]  i_timestamp,
    input  wis_pkg::t_queue_status      i_q_status,
    output logic                        o_stall,
    output logic                        o_q_push,
    output wis_pkg::t_cmd               o_q_cmd
);

    logic [wis_pkg::TIME_W-1:0] r_last_start;
    logic [wis_pkg::TIME_W-1:0] n_last_start;
    logic                       w_accept;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !i_q_status.full;

    always_comb begin
        n_last_start   = r_last_start;
        o_q_push       = 1'b0;
        o_q_cmd.op     = wis_pkg::CMD_CLEAR;
        o_q_cmd.sample = i_timestamp - r_last_start;
        case (i_op)
            wis_pkg::OP_START: begin
                o_q_cmd.op   = wis_pkg::CMD_PERIOD;
                o_q_push     = w_accept;
                n_last_start = w_accept ? i_timestamp : r_last_start;
            end
            wis_pkg::OP_STOP: begin
                o_q_cmd.op = wis_pkg::CMD_DURATION;
                o_q_push   = w_accept;
            end
            wis_pkg::OP_CLEAR: begin
                o_q_cmd.op = wis_pkg::CMD_CLEAR;
                o_q_push   = w_accept;
            end
            default: begin
                // The unused code is taken and dropped.
                o_q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_start <= '0;
        end else begin
            r_last_start <= n_last_start;
        end
    end

endmodule

// ----- rtl/wis_queue.sv -----
module wis_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  wis_pkg::t_cmd           i_cmd,
    input  logic                    i_pop,
    output wis_pkg::t_cmd           o_cmd,
    output wis_pkg::t_queue_status  o_status
);

    localparam int unsigned QP_W = $clog2(wis_pkg::QUEUE_DEPTH);
    localparam int unsigned QC_W = $clog2(wis_pkg::QUEUE_DEPTH + 1);

    wis_pkg::t_cmd   r_mem [wis_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr;
    logic [QP_W-1:0] r_rd;
    logic [QC_W-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_status.valid = (r_cnt != '0);
    assign o_status.full  = (r_cnt == QC_W'(wis_pkg::QUEUE_DEPTH));
    assign o_cmd          = r_mem[r_rd];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QP_W'(wis_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QP_W'(wis_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/wis_back.sv -----
module wis_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wis_pkg::CNT_W-1:0]   i_window_size,
    input  wis_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_window_kind,
    output logic [wis_pkg::CNT_W-1:0]   o_sample_count,
    output logic [wis_pkg::TIME_W-1:0]  o_last_value,
    output logic [wis_pkg::TIME_W-1:0]  o_mean_value,
    output logic [wis_pkg::TIME_W-1:0]  o_std_dev,
    output logic [wis_pkg::TIME_W-1:0]  o_min_value,
    output logic [wis_pkg::TIME_W-1:0]  o_max_value
);

    localparam int unsigned TW  = wis_pkg::TIME_W;
    localparam int unsigned PW  = wis_pkg::PTR_W;
    localparam int unsigned CW  = wis_pkg::CNT_W;
    localparam int unsigned SW  = wis_pkg::SUM_W;
    localparam int unsigned AW  = wis_pkg::ACC_W;
    localparam int unsigned RW  = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1_RD,
        S_P1_ACC,
        S_DIV,
        S_P2_RD,
        S_P2_DIFF,
        S_P2_MUL,
        S_P2_ADD,
        S_SQRT,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [TW-1:0]    r_store [2 * wis_pkg::DEPTH];
    logic [TW-1:0]    r_mem_q;
    logic [CW-1:0]    r_cnt [2];
    logic [PW-1:0]    r_ptr [2];
    logic             r_kind;
    logic [CW-1:0]    r_n;
    logic [PW-1:0]    r_base;
    logic [CW-1:0]    r_i;
    logic [TW-1:0]    r_sample;
    logic [SW-1:0]    r_sum;
    logic [TW-1:0]    r_min;
    logic [TW-1:0]    r_max;
    logic [TW-1:0]    r_mean;
    logic [TW-1:0]    r_d;
    logic [2*TW-1:0]  r_prod;
    logic [AW-1:0]    r_acc;
    logic [AW-1:0]    r_div;
    logic [RW-1:0]    r_rem;
    logic [CW-1:0]    r_steps;
    logic             r_div_var;
    logic [2*TW-1:0]  r_sq_v;
    logic [TW+1:0]    r_sq_rem;
    logic [TW-1:0]    r_root;

    logic [CW-1:0]    w_lim;
    logic [CW-1:0]    w_n;
    logic             w_kind;
    logic             w_push;
    logic [PW:0]      w_raddr;
    logic [RW-1:0]    w_div_cur;
    logic             w_div_ge;
    logic [RW-1:0]    n_rem;
    logic [AW-1:0]    n_div;
    logic [TW+1:0]    w_sq_cur;
    logic [TW+1:0]    w_sq_trial;
    logic             w_sq_ge;
    logic             w_out_free;

    // A window size of zero acts as one, and one above the store depth as the depth.
    always_comb begin
        if (i_window_size == '0) begin
            w_lim = CW'(1);
        end else if (i_window_size > CW'(wis_pkg::DEPTH)) begin
            w_lim = CW'(wis_pkg::DEPTH);
        end else begin
            w_lim = i_window_size;
        end
    end

    assign w_kind  = (i_cmd.op == wis_pkg::CMD_DURATION);
    assign w_n     = (r_cnt[w_kind] >= w_lim) ? w_lim : r_cnt[w_kind] + 1'b1;
    assign o_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign w_push  = o_pop && (i_cmd.op != wis_pkg::CMD_CLEAR);
    assign w_raddr = {r_kind, r_base - r_i[PW-1:0]};

    assign w_div_cur = {r_rem[RW-2:0], r_div[AW-1]};
    assign w_div_ge  = (w_div_cur >= RW'(r_n));
    assign n_rem     = w_div_ge ? w_div_cur - RW'(r_n) : w_div_cur;
    assign n_div     = {r_div[AW-2:0], w_div_ge};

    assign w_sq_cur   = {r_sq_rem[TW-1:0], r_sq_v[2*TW-1 -: 2]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = (w_sq_cur >= w_sq_trial);

    assign w_out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_store[{w_kind, r_ptr[w_kind]}] <= i_cmd.sample;
        end
        r_mem_q <= r_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '{default: '0};
            r_ptr   <= '{default: '0};
            o_valid <= 1'b0;
        end else begin
            // In the final state the result register is refilled instead.
            if (o_valid && !i_stall && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.op == wis_pkg::CMD_CLEAR) begin
                            r_cnt <= '{default: '0};
                            r_ptr <= '{default: '0};
                        end else begin
                            r_ptr[w_kind] <= r_ptr[w_kind] + 1'b1;
                            r_cnt[w_kind] <= w_n;
                            r_n      <= w_n;
                            r_kind   <= w_kind;
                            r_base   <= r_ptr[w_kind];
                            r_i      <= '0;
                            r_sum    <= '0;
                            r_sample <= i_cmd.sample;
                            r_state  <= S_P1_RD;
                        end
                    end
                end
                S_P1_RD: begin
                    r_state <= S_P1_ACC;
                end
                S_P1_ACC: begin
                    r_sum <= r_sum + SW'(r_mem_q);
                    if (r_i == '0 || r_mem_q < r_min) begin
                        r_min <= r_mem_q;
                    end
                    if (r_i == '0 || r_mem_q > r_max) begin
                        r_max <= r_mem_q;
                    end
                    if (r_i + 1'b1 == r_n) begin
                        // The sum is placed at the top so that only its own bits are stepped.
                        r_div     <= {r_sum + SW'(r_mem_q), (AW - SW)'(0)};
                        r_rem     <= '0;
                        r_steps   <= CW'(SW);
                        r_div_var <= 1'b0;
                        r_state   <= S_DIV;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_P1_RD;
                    end
                end
                S_DIV: begin
                    r_div   <= n_div;
                    r_rem   <= n_rem;
                    r_steps <= r_steps - 1'b1;
                    if (r_steps == CW'(1)) begin
                        if (!r_div_var) begin
                            r_mean  <= n_div[TW-1:0];
                            r_i     <= '0;
                            r_acc   <= '0;
                            r_state <= S_P2_RD;
                        end else begin
                            r_sq_v   <= n_div[2*TW-1:0];
                            r_sq_rem <= '0;
                            r_root   <= '0;
                            r_steps  <= CW'(TW);
                            r_state  <= S_SQRT;
                        end
                    end
                end
                S_P2_RD: begin
                    r_state <= S_P2_DIFF;
                end
                S_P2_DIFF: begin
                    r_d     <= (r_mem_q >= r_mean) ? r_mem_q - r_mean : r_mean - r_mem_q;
                    r_state <= S_P2_MUL;
                end
                S_P2_MUL: begin
                    r_prod  <= r_d * r_d;
                    r_state <= S_P2_ADD;
                end
                S_P2_ADD: begin
                    if (r_i + 1'b1 == r_n) begin
                        r_div     <= r_acc + AW'(r_prod);
                        r_rem     <= '0;
                        r_steps   <= CW'(AW);
                        r_div_var <= 1'b1;
                        r_state   <= S_DIV;
                    end else begin
                        r_acc   <= r_acc + AW'(r_prod);
                        r_i     <= r_i + 1'b1;
                        r_state <= S_P2_RD;
                    end
                end
                S_SQRT: begin
                    r_sq_v  <= {r_sq_v[2*TW-3:0], 2'b00};
                    r_steps <= r_steps - 1'b1;
                    if (w_sq_ge) begin
                        r_sq_rem <= w_sq_cur - w_sq_trial;
                        r_root   <= {r_root[TW-2:0], 1'b1};
                    end else begin
                        r_sq_rem <= w_sq_cur;
                        r_root   <= {r_root[TW-2:0], 1'b0};
                    end
                    if (r_steps == CW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_valid        <= 1'b1;
                        o_window_kind  <= r_kind;
                        o_sample_count <= r_n;
                        o_last_value   <= r_sample;
                        o_mean_value   <= r_mean;
                        o_std_dev      <= r_root;
                        o_min_value    <= r_min;
                        o_max_value    <= r_max;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_n_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n != '0))
        else $error("window count is zero during processing");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(wis_pkg::DEPTH)) && (r_cnt[1] <= CW'(wis_pkg::DEPTH)))
        else $error("window count exceeds store depth");
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_value <= o_mean_value) && (o_mean_value <= o_max_value))
        else $error("mean outside min and max");
    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_count != '0) && (o_sample_count <= CW'(wis_pkg::DEPTH)))
        else $error("reported count out of range");
`endif

endmodule

// ----- rtl/windowed_interval_statistics.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// input    | i_valid / o_stall   | i_op, i_timestamp
// result   | o_valid / i_stall   | o_window_kind, o_sample_count, o_last_value,
//          |                     | o_mean_value, o_std_dev, o_min_value, o_max_value
// config   | i_cfg_we            | i_cfg_data (window size)
//
// A start or stop request is worked through in the back end in two passes over the
// sample store (read and accumulate per sample, then read, difference, multiply and add
// per sample, one registered memory port), a bit-serial divider for mean and variance,
// and a bit-serial square root. A clear request empties both windows and gives no result.
// Reset is synchronous and active low; the windows start empty and the window size at 64.
// A two-entry request queue lets the input keep accepting while the back end works or a
// result is stalled, until the queue is full.
module windowed_interval_statistics (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wis_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [wis_pkg::TIME_W-1:0]  i_timestamp,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_window_kind,
    output logic [wis_pkg::CNT_W-1:0]   o_sample_count,
    output logic [wis_pkg::TIME_W-1:0]  o_last_value,
    output logic [wis_pkg::TIME_W-1:0]  o_mean_value,
    output logic [wis_pkg::TIME_W-1:0]  o_std_dev,
    output logic [wis_pkg::TIME_W-1:0]  o_min_value,
    output logic [wis_pkg::TIME_W-1:0]  o_max_value
);

    logic [wis_pkg::CNT_W-1:0] r_window_size;
    wis_pkg::t_queue_status    w_q_status;
    wis_pkg::t_cmd             w_push_cmd;
    wis_pkg::t_cmd             w_pop_cmd;
    logic                      w_push;
    logic                      w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= wis_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_size <= i_cfg_data;
        end
    end

    wis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_timestamp (i_timestamp),
        .i_q_status  (w_q_status),
        .o_stall     (o_stall),
        .o_q_push    (w_push),
        .o_q_cmd     (w_push_cmd)
    );

    wis_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_pop_cmd),
        .o_status (w_q_status)
    );

    wis_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_size  (r_window_size),
        .i_cmd          (w_pop_cmd),
        .i_cmd_valid    (w_q_status.valid),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_window_kind  (o_window_kind),
        .o_sample_count (o_sample_count),
        .o_last_value   (o_last_value),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value)
    );

endmodule

// ----- tb/windowed_interval_statistics_tb.sv -----
module windowed_interval_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        bit        kind;
        bit [6:0]  count;
        bit [31:0] last;
        bit [31:0] mean;
        bit [31:0] sdev;
        bit [31:0] mn;
        bit [31:0] mx;
    } t_stats;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class interval_scoreboard;
        bit [31:0] period_ring[64];
        bit [31:0] duration_ring[64];
        int        period_n, duration_n, period_wr, duration_wr;
        bit [31:0] start_time;
        int        win_size;
        t_stats    pending[$];
        int        checked;

        function new();
            period_n = 0; duration_n = 0; period_wr = 0; duration_wr = 0;
            start_time = 0; win_size = 64; checked = 0;
        endfunction

        function void set_window(bit [6:0] v);
            win_size = (v == 0) ? 1 : (v > 64 ? 64 : v);
        endfunction

        function bit [31:0] root(bit [127:0] v);
            bit [63:0] r;
            bit [63:0] c;
            r = 0;
            for (int b = 48; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (128'(c) * 128'(c) <= v) r = c;
            end
            return r[31:0];
        endfunction

        function t_stats window_stats(ref bit [31:0] ring[64], ref int n, ref int wr,
                                      input bit [31:0] sample, input bit kind);
            t_stats s;
            bit [31:0] x;
            bit [63:0] sum, mean, d;
            bit [127:0] acc;
            ring[wr] = sample;
            wr = (wr + 1) % 64;
            n = (n + 1 > win_size) ? win_size : n + 1;
            sum = 0; acc = 0;
            s.mn = '1; s.mx = 0;
            for (int i = 0; i < n; i++) begin
                x = ring[(wr + 63 - i) % 64];
                sum += x;
                if (x < s.mn) s.mn = x;
                if (x > s.mx) s.mx = x;
            end
            mean = sum / n;
            for (int i = 0; i < n; i++) begin
                x = ring[(wr + 63 - i) % 64];
                d = (x >= mean) ? x - mean : mean - x;
                acc += 128'(d) * 128'(d);
            end
            s.kind = kind; s.count = 7'(n); s.last = sample; s.mean = mean[31:0];
            s.sdev = root(acc / n);
            return s;
        endfunction

        function void note_request(bit [1:0] op, bit [31:0] ts);
            bit [31:0] sample;
            sample = ts - start_time;
            if (op == wis_pkg::OP_START) begin
                start_time = ts;
                pending = {pending,
                           window_stats(period_ring, period_n, period_wr, sample, 0)};
            end else if (op == wis_pkg::OP_STOP) begin
                pending = {pending, window_stats(duration_ring, duration_n, duration_wr,
                                                 sample, 1)};
            end else if (op == wis_pkg::OP_CLEAR) begin
                period_n = 0; duration_n = 0; period_wr = 0; duration_wr = 0;
            end
        endfunction

        task check_result(t_stats got);
            t_stats e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result kind", got.kind, -1);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.kind != e.kind) report_mismatch("window_kind", got.kind, e.kind);
            if (got.count != e.count) report_mismatch("sample_count", got.count, e.count);
            if (got.last != e.last) report_mismatch("last_value", got.last, e.last);
            if (got.mean != e.mean) report_mismatch("mean_value", got.mean, e.mean);
            if (got.sdev != e.sdev) report_mismatch("std_dev", got.sdev, e.sdev);
            if (got.mn != e.mn) report_mismatch("min_value", got.mn, e.mn);
            if (got.mx != e.mx) report_mismatch("max_value", got.mx, e.mx);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, i_cfg_we = 0, i_valid = 0, i_stall = 0;
    logic [wis_pkg::CNT_W-1:0] i_cfg_data = '0;
    logic [1:0] i_op = '0;
    logic [wis_pkg::TIME_W-1:0] i_timestamp = '0;
    logic o_stall, o_valid, o_window_kind;
    logic [wis_pkg::CNT_W-1:0] o_sample_count;
    logic [wis_pkg::TIME_W-1:0] o_last_value, o_mean_value, o_std_dev, o_min_value;
    logic [wis_pkg::TIME_W-1:0] o_max_value;

    interval_scoreboard sb = new();
    bit [31:0] clock_now = 0;
    int requests_sent = 0;

    always #5 i_clk = ~i_clk;

    windowed_interval_statistics dut (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Valid stays high after acceptance; it is dropped when a gap follows or the bench waits for idle.
    task automatic send_request(bit [1:0] op, bit [31:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_timestamp <= ts;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(op, ts);
        requests_sent++;
    endtask

    // Timestamps advance from a running clock with a random step of varied size, or jump to a random value.
    task automatic send_event(bit [1:0] op);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) clock_now += $urandom_range(1, 5000);
        else if (r < 8) clock_now += $urandom;
        else if (r < 9) clock_now += 0;
        else clock_now = $urandom;
        send_request(op, clock_now);
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
    endtask

    task automatic write_window(bit [6:0] v);
        i_cfg_we <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_window(v);
    endtask

    // Result side: random stall, sampled at the edge.
    always @(posedge i_clk) begin
        t_stats g;
        if (i_rst_n && o_valid && !i_stall) begin
            g.kind = o_window_kind; g.count = o_sample_count; g.last = o_last_value;
            g.mean = o_mean_value; g.sdev = o_std_dev; g.mn = o_min_value;
            g.mx = o_max_value;
            sb.check_result(g);
        end
    end

    initial begin
        int r;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (requests_sent > 300 && requests_sent < 360) i_stall <= 0;
            else if (r < 60) i_stall <= 0;
            else if (r < 97) i_stall <= 1;
            else begin
                i_stall <= 1;
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end
        end
    end

    initial begin
        bit [6:0] sizes[6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd17};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extreme timestamps, wrap-around, zero-length intervals, clear, op 3.
        send_request(wis_pkg::OP_START, 32'hFFFF_FFFF);
        send_request(wis_pkg::OP_STOP, 32'h0000_0000);
        send_request(wis_pkg::OP_START, 32'h0000_0000);
        send_request(wis_pkg::OP_START, 32'h0000_0000);
        send_request(wis_pkg::OP_STOP, 32'hFFFF_FFFF);
        send_request(wis_pkg::OP_STOP, 32'h8000_0000);
        send_request(OP_SPARE, 32'h1234_5678);
        send_request(wis_pkg::OP_START, 32'h7FFF_FFFF);
        send_request(wis_pkg::OP_START, 32'hAAAA_AAAA);
        send_request(wis_pkg::OP_STOP, 32'h5555_5555);
        send_request(wis_pkg::OP_CLEAR, 32'hFFFF_FFFF);
        send_request(wis_pkg::OP_STOP, 32'hAAAA_AAAB);
        send_request(wis_pkg::OP_START, 32'h0000_0001);
        send_request(wis_pkg::OP_CLEAR, 32'h0);
        clock_now = 32'h1;
        wait_idle();

        foreach (sizes[k]) begin
            write_window(sizes[k]);
            for (int i = 0; i < 110; i++) begin
                r_pick: begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r < 48) send_event(wis_pkg::OP_START);
                    else if (r < 95) send_event(wis_pkg::OP_STOP);
                    else if (r < 98) send_event(wis_pkg::OP_CLEAR);
                    else send_request(OP_SPARE, $urandom);
                end
            end
            wait_idle();
        end
        write_window(7'd64);
        $display("%0d requests sent, %0d results checked over six window sizes",
                 requests_sent, sb.checked);
        if (errors == 0 && sb.pending.size() == 0)
            $display("windowed_interval_statistics_tb OK");
        else
            $display("windowed_interval_statistics_tb NOT OK");
        $finish;
    end

    initial begin
        #30ms;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("windowed_interval_statistics_tb NOT OK");
        $finish;
    end
endmodule
